[hdl/trc_pkg.sv]
// ----------------------------------------------------------------------------
// trc_pkg
// Shared constants and types of the thresholded band centroid finder: the
// configuration register map, field widths and reset values.
// ----------------------------------------------------------------------------
package trc_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 128;

  localparam int PIX_W = 8;
  localparam int TH_W  = 8;
  localparam int OX_W  = 9;
  localparam int OY_W  = 8;

  localparam int FW_W  = 9;
  localparam int FH_W  = 8;
  localparam int OFS_W = 8;
  localparam int MIN_W = 16;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam int OUT_USED_W  = TH_W + 3 * (1 + OX_W + OY_W);
  localparam int OUT_TDATA_W = 64;

  localparam logic [FW_W-1:0]  FW_RST  = 9'd160;
  localparam logic [FH_W-1:0]  FH_RST  = 8'd120;
  localparam logic [OFS_W-1:0] OFS_RST = 8'd25;
  localparam logic [MIN_W-1:0] MIN_RST = 16'd800;

  localparam logic [TH_W-1:0] TH_MAX = 8'd255;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_THRESHOLD_OFFSET,
    REG_MIN_DARK_PIXELS
  } reg_idx_t;

  typedef enum logic [1:0] {
    BAND_TOP,
    BAND_MID,
    BAND_BOT
  } band_t;

  typedef struct packed {
    logic              found;
    logic [OX_W-1:0]   x;
    logic [OY_W-1:0]   y;
  } band_res_t;

endpackage

[hdl/thresholded_roi_centroid.sv]
// ----------------------------------------------------------------------------
// thresholded_roi_centroid
// Finds the dark-pixel centroids of three row bands of a grayscale frame
// under a threshold derived from the frame's mean brightness.
// ----------------------------------------------------------------------------
// Pixels arrive on the in_ stream in raster order, one item per pixel, and
// are written to an on-chip frame store at one item per cycle. A frame ends
// on the pixel that brings the count to frame_width times frame_height.
// After that pixel in_tready stays low while the block works: the mean is
// found by a shared bit-serial divider (dividend width 23 at the default
// geometry), then the stored frame is read back at one pixel per cycle,
// then each band is checked, and a band that is found takes two divisions
// for its column and row centroid. The result item waits in an output
// register; pixel intake for the next frame resumes at once, and only the
// loading of the following result waits while out_tready is low. Reset
// clears the pixel count, the brightness sum and the output valid, and sets
// the registers to their defaults. The frame store needs no clearing.
// Registers are to be written over the APB port only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module thresholded_roi_centroid #(
  parameter int MAX_WIDTH  = trc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = trc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] pixel
  input  logic [trc_pkg::PIX_W-1:0]        in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] threshold, [8] top_found, [17:9] top_x, [25:18] top_y,
  // [26] mid_found, [35:27] mid_x, [43:36] mid_y, [44] bottom_found,
  // [53:45] bottom_x, [61:54] bottom_y, [63:62] zero
  output logic [trc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [trc_pkg::APB_AW-1:0]       paddr,
  input  logic [trc_pkg::APB_DW-1:0]       pwdata,
  output logic [trc_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);

  import trc_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int SW    = AW + PIX_W;
  localparam int XSW   = AW + XW;
  localparam int YSW   = AW + YW;
  localparam int DW0   = (SW > XSW) ? SW : XSW;
  localparam int DW    = (DW0 > YSW) ? DW0 : YSW;
  localparam int WCW   = (WW > FW_W) ? WW : FW_W;
  localparam int HCW   = (HW > FH_W) ? HW : FH_W;
  localparam int MCW   = (CW > MIN_W) ? CW : MIN_W;
  localparam int TW    = WW + HW;
  localparam int YCW   = HW + 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEAN,
    S_PASS,
    S_DRAIN,
    S_BAND,
    S_DIVX,
    S_DIVY,
    S_OUT
  } state_t;

  state_t st_r, st_nxt;

  logic [FW_W-1:0]  fw_r;
  logic [FH_W-1:0]  fh_r;
  logic [OFS_W-1:0] ofs_r;
  logic [MIN_W-1:0] min_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [SW-1:0]    sum_r, sum_nxt;
  logic [TH_W-1:0]  th_r, th_nxt;

  logic [XW-1:0]    x_r, x_nxt;
  logic [YW-1:0]    y_r, y_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic             v_d_r, v_d_nxt;
  logic [XW-1:0]    x_d_r, x_d_nxt;
  logic [YW-1:0]    y_d_r, y_d_nxt;
  band_t            b_d_r, b_d_nxt;
  band_t            bi_r, bi_nxt;

  logic [XSW-1:0]   col_r [3];
  logic [XSW-1:0]   col_nxt [3];
  logic [YSW-1:0]   row_r [3];
  logic [YSW-1:0]   row_nxt [3];
  logic [CW-1:0]    dcnt_r [3];
  logic [CW-1:0]    dcnt_nxt [3];
  band_res_t        res_r [3];
  band_res_t        res_nxt [3];

  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [WCW-1:0]   fw_ext;
  logic [HCW-1:0]   fh_ext;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [TW-1:0]    total;
  logic [CW-1:0]    cnt_inc;
  logic [SW-1:0]    sum_inc;
  logic             in_fire;
  logic [XW-1:0]    w_last;
  logic [YW-1:0]    h_last;
  logic [YCW-1:0]   y1;
  logic [YCW-1:0]   y3;
  band_t            band_cur;
  logic             dark;
  logic             found;
  logic [DW-1:0]    mean_diff;

  logic             ram_we;
  logic             ram_re;
  logic [PIX_W-1:0] ram_rdata;

  logic             div_start;
  logic [DW-1:0]    div_dividend;
  logic [CW-1:0]    div_divisor;
  logic             div_done;
  logic [DW-1:0]    div_q;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:      prdata = APB_DW'(fw_r);
      REG_FRAME_HEIGHT:     prdata = APB_DW'(fh_r);
      REG_THRESHOLD_OFFSET: prdata = APB_DW'(ofs_r);
      REG_MIN_DARK_PIXELS:  prdata = APB_DW'(min_r);
    endcase
  end

  // Effective geometry.
  assign fw_ext = WCW'(fw_r);
  assign fh_ext = HCW'(fh_r);

  always_comb begin
    if (fw_ext == '0) begin
      w_eff = WW'(1);
    end else if (fw_ext > WCW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_ext);
    end
    if (fh_ext == '0) begin
      h_eff = HW'(1);
    end else if (fh_ext > HCW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(fh_ext);
    end
  end

  assign total   = TW'(w_eff) * TW'(h_eff);
  assign w_last  = XW'(w_eff - WW'(1));
  assign h_last  = YW'(h_eff - HW'(1));
  assign in_fire = in_tvalid & in_tready;
  assign cnt_inc = CW'(cnt_r) + CW'(1);
  assign sum_inc = sum_r + SW'(in_tdata);

  // Row y is in the top band when 3*(y+1) <= h, in the middle band when
  // 3*(y+1) <= 2h.
  assign y1 = YCW'(y_r) + YCW'(1);
  assign y3 = y1 + {y1[YCW-2:0], 1'b0};

  always_comb begin
    if (y3 <= YCW'(h_eff)) begin
      band_cur = BAND_TOP;
    end else if (y3 <= YCW'({h_eff, 1'b0})) begin
      band_cur = BAND_MID;
    end else begin
      band_cur = BAND_BOT;
    end
  end

  assign dark      = (ram_rdata < th_r);
  assign found     = (dcnt_r[bi_r] != '0) && (MCW'(dcnt_r[bi_r]) >= MCW'(min_r));
  assign mean_diff = div_q - DW'(ofs_r);

  assign ram_we = in_fire;
  assign ram_re = (st_r == S_PASS);

  trc_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_r),
    .wr_data (in_tdata),
    .rd_en   (ram_re),
    .rd_addr (addr_r),
    .rd_data (ram_rdata)
  );

  trc_div #(
    .DIVIDEND_W (DW),
    .DIVISOR_W  (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    th_nxt         = th_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    addr_nxt       = addr_r;
    v_d_nxt        = 1'b0;
    x_d_nxt        = x_r;
    y_d_nxt        = y_r;
    b_d_nxt        = band_cur;
    bi_nxt         = bi_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    div_start      = 1'b0;
    div_dividend   = DW'(sum_inc);
    div_divisor    = cnt_inc;
    in_tready      = 1'b0;
    for (int i = 0; i < 3; i++) begin
      col_nxt[i]  = col_r[i];
      row_nxt[i]  = row_r[i];
      dcnt_nxt[i] = dcnt_r[i];
      res_nxt[i]  = res_r[i];
      if (v_d_r && dark && (b_d_r == 2'(i))) begin
        col_nxt[i]  = col_r[i] + XSW'(x_d_r);
        row_nxt[i]  = row_r[i] + YSW'(y_d_r);
        dcnt_nxt[i] = dcnt_r[i] + CW'(1);
      end
    end

    unique case (st_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (TW'(cnt_inc) >= total) begin
            div_start = 1'b1;
            cnt_nxt   = '0;
            sum_nxt   = '0;
            st_nxt    = S_MEAN;
          end else begin
            cnt_nxt = AW'(cnt_inc);
            sum_nxt = sum_inc;
          end
        end
      end
      S_MEAN: begin
        if (div_done) begin
          if (div_q < DW'(ofs_r)) begin
            th_nxt = '0;
          end else if (mean_diff > DW'(TH_MAX)) begin
            th_nxt = TH_MAX;
          end else begin
            th_nxt = TH_W'(mean_diff);
          end
          x_nxt    = '0;
          y_nxt    = '0;
          addr_nxt = '0;
          for (int i = 0; i < 3; i++) begin
            col_nxt[i]  = '0;
            row_nxt[i]  = '0;
            dcnt_nxt[i] = '0;
          end
          st_nxt = S_PASS;
        end
      end
      S_PASS: begin
        v_d_nxt  = 1'b1;
        addr_nxt = addr_r + AW'(1);
        if (x_r == w_last) begin
          x_nxt = '0;
          y_nxt = y_r + YW'(1);
          if (y_r == h_last) begin
            st_nxt = S_DRAIN;
          end
        end else begin
          x_nxt = x_r + XW'(1);
        end
      end
      S_DRAIN: begin
        bi_nxt = BAND_TOP;
        st_nxt = S_BAND;
      end
      S_BAND: begin
        div_dividend = DW'(col_r[bi_r]);
        div_divisor  = dcnt_r[bi_r];
        if (found) begin
          div_start = 1'b1;
          st_nxt    = S_DIVX;
        end else begin
          res_nxt[bi_r] = '{found: 1'b0, x: '1, y: '1};
          if (bi_r == BAND_BOT) begin
            st_nxt = S_OUT;
          end else begin
            bi_nxt = (bi_r == BAND_TOP) ? BAND_MID : BAND_BOT;
          end
        end
      end
      S_DIVX: begin
        div_dividend = DW'(row_r[bi_r]);
        div_divisor  = dcnt_r[bi_r];
        if (div_done) begin
          res_nxt[bi_r].found = 1'b1;
          res_nxt[bi_r].x     = OX_W'(div_q);
          div_start           = 1'b1;
          st_nxt              = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          res_nxt[bi_r].y = OY_W'(div_q);
          if (bi_r == BAND_BOT) begin
            st_nxt = S_OUT;
          end else begin
            bi_nxt = (bi_r == BAND_TOP) ? BAND_MID : BAND_BOT;
            st_nxt = S_BAND;
          end
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {(OUT_TDATA_W - OUT_USED_W)'(0),
                            res_r[BAND_BOT].y, res_r[BAND_BOT].x, res_r[BAND_BOT].found,
                            res_r[BAND_MID].y, res_r[BAND_MID].x, res_r[BAND_MID].found,
                            res_r[BAND_TOP].y, res_r[BAND_TOP].x, res_r[BAND_TOP].found,
                            th_r};
          st_nxt         = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      cnt_r        <= '0;
      sum_r        <= '0;
      v_d_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
      fw_r         <= FW_RST;
      fh_r         <= FH_RST;
      ofs_r        <= OFS_RST;
      min_r        <= MIN_RST;
    end else begin
      st_r         <= st_nxt;
      cnt_r        <= cnt_nxt;
      sum_r        <= sum_nxt;
      v_d_r        <= v_d_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_FRAME_WIDTH:      fw_r  <= pwdata[FW_W-1:0];
          REG_FRAME_HEIGHT:     fh_r  <= pwdata[FH_W-1:0];
          REG_THRESHOLD_OFFSET: ofs_r <= pwdata[OFS_W-1:0];
          REG_MIN_DARK_PIXELS:  min_r <= pwdata[MIN_W-1:0];
        endcase
      end
    end
    th_r        <= th_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    addr_r      <= addr_nxt;
    x_d_r       <= x_d_nxt;
    y_d_r       <= y_d_nxt;
    b_d_r       <= b_d_nxt;
    bi_r        <= bi_nxt;
    out_tdata_r <= out_tdata_nxt;
    for (int i = 0; i < 3; i++) begin
      col_r[i]  <= col_nxt[i];
      row_r[i]  <= row_nxt[i];
      dcnt_r[i] <= dcnt_nxt[i];
      res_r[i]  <= res_nxt[i];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_store_addr: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> CW'(cnt_r) < CW'(DEPTH))
    else $error("frame store write beyond its depth");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_BAND) && (bi_r == BAND_TOP) |->
      ((CW + 2)'(dcnt_r[0]) + (CW + 2)'(dcnt_r[1]) + (CW + 2)'(dcnt_r[2]))
        <= (CW + 2)'(total))
    else $error("dark pixel counts exceed the frame size");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(st_r == S_OUT))
    else $error("result item raised outside the output stage");

endmodule

[hdl/trc_ram.sv]
// ----------------------------------------------------------------------------
// trc_ram
// Generic simple dual-port RAM with one write port and one registered read
// port.
// ----------------------------------------------------------------------------
module trc_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/trc_div.sv]
// ----------------------------------------------------------------------------
// trc_div
// Unsigned restoring divider. One quotient bit per cycle; the quotient is
// valid in the cycle where done is high.
// ----------------------------------------------------------------------------
module trc_div #(
  parameter int DIVIDEND_W = 23,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int NW = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [NW-1:0]         cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] q_r, q_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  ge;

  assign rem_sh  = {rem_r, q_r[DIVIDEND_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign ge      = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = NW'(DIVIDEND_W);
      rem_nxt  = '0;
      q_nxt    = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      q_nxt   = {q_r[DIVIDEND_W-2:0], ge};
      cnt_nxt = cnt_r - NW'(1);
      if (cnt_r == NW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("divider busy with an exhausted bit count");

  a_divisor_held: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && $past(busy_r) |-> $stable(dvs_r))
    else $error("divisor changed during a division");

endmodule
